[hdl/fmv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_pkg
// Shared widths, codes and types of the fused matrix-vector multiplier.
// ----------------------------------------------------------------------------
package fmv_pkg;

  localparam int ModeW    = 1;
  localparam int IndexW   = 12;
  localparam int ValueW   = 16;
  localparam int MatrixW  = 2;
  localparam int RowW     = 16;
  localparam int ResultW  = 48;
  localparam int RowLenW  = 13;
  localparam int LayoutW  = 2;
  localparam int RowsW    = 16;
  localparam int CrowW    = 18;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = 2;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  localparam logic [LayoutW-1:0] LAYOUT_SINGLE = 2'd0;
  localparam logic [LayoutW-1:0] LAYOUT_PAIR   = 2'd1;
  localparam logic [LayoutW-1:0] LAYOUT_TRIPLE = 2'd2;

  localparam logic [MatrixW-1:0] MAT_FIRST  = 2'd0;
  localparam logic [MatrixW-1:0] MAT_SECOND = 2'd1;
  localparam logic [MatrixW-1:0] MAT_THIRD  = 2'd2;

  localparam logic [RegIdxW-1:0] REG_ROW_LENGTH  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_LAYOUT      = 2'd1;
  localparam logic [RegIdxW-1:0] REG_FIRST_ROWS  = 2'd2;
  localparam logic [RegIdxW-1:0] REG_SECOND_ROWS = 2'd3;

  localparam logic [RowLenW-1:0] ROW_LENGTH_RST  = 13'd4096;
  localparam logic [LayoutW-1:0] LAYOUT_RST      = LAYOUT_SINGLE;
  localparam logic [RowsW-1:0]   FIRST_ROWS_RST  = 16'd1;
  localparam logic [RowsW-1:0]   SECOND_ROWS_RST = 16'd1;

  typedef struct packed {
    logic [RowLenW-1:0] row_length;
    logic [LayoutW-1:0] layout;
    logic [RowsW-1:0]   first_rows;
    logic [RowsW-1:0]   second_rows;
  } cfg_t;

  // tag that travels with each request down the pipeline
  typedef struct packed {
    logic               load;
    logic               row_end;
    logic [MatrixW-1:0] matrix;
    logic [RowW-1:0]    row;
    logic               last;
  } tag_t;

endpackage
`default_nettype wire

[hdl/fmv_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_if
// Valid/ready channels for requests into and results out of the multiplier.
// ----------------------------------------------------------------------------
interface fmv_req_if;
  logic                               valid;
  logic                               ready;
  logic [fmv_pkg::ModeW-1:0]          mode;
  logic [fmv_pkg::IndexW-1:0]         vector_index;
  logic signed [fmv_pkg::ValueW-1:0]  value;

  modport source (output valid, mode, vector_index, value, input ready);
  modport sink   (input valid, mode, vector_index, value, output ready);
endinterface

interface fmv_res_if;
  logic                               valid;
  logic                               ready;
  logic [fmv_pkg::MatrixW-1:0]        matrix;
  logic [fmv_pkg::RowW-1:0]           row;
  logic signed [fmv_pkg::ResultW-1:0] result;
  logic                               last;

  modport source (output valid, matrix, row, result, last, input ready);
  modport sink   (input valid, matrix, row, result, last, output ready);
endinterface
`default_nettype wire

[hdl/fmv_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_cfg
// APB register file: row length, layout and matrix row counts.
// ----------------------------------------------------------------------------
module fmv_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [fmv_pkg::CfgAddrW-1:0]  paddr_i,
  input  wire logic [fmv_pkg::CfgDataW-1:0]  pwdata_i,
  output logic      [fmv_pkg::CfgDataW-1:0]  prdata_o,
  output logic                               pready_o,
  output fmv_pkg::cfg_t                      cfg_o
);
  import fmv_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr_i[CfgAddrW-1:2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ROW_LENGTH:  cfg_d.row_length  = pwdata_i[RowLenW-1:0];
        REG_LAYOUT:      cfg_d.layout      = pwdata_i[LayoutW-1:0];
        REG_FIRST_ROWS:  cfg_d.first_rows  = pwdata_i[RowsW-1:0];
        REG_SECOND_ROWS: cfg_d.second_rows = pwdata_i[RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_LENGTH:  prdata_o = CfgDataW'(cfg_q.row_length);
      REG_LAYOUT:      prdata_o = CfgDataW'(cfg_q.layout);
      REG_FIRST_ROWS:  prdata_o = CfgDataW'(cfg_q.first_rows);
      REG_SECOND_ROWS: prdata_o = CfgDataW'(cfg_q.second_rows);
      default:         prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_length  <= ROW_LENGTH_RST;
      cfg_q.layout      <= LAYOUT_RST;
      cfg_q.first_rows  <= FIRST_ROWS_RST;
      cfg_q.second_rows <= SECOND_ROWS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule
`default_nettype wire

[hdl/fmv_vstore.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_vstore
// Vector element memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmv_vstore #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic signed [WIDTH-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0]      rdata_o
);

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read so a stalled pipeline keeps it
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hdl/fmv_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_seq
// Column and row sequencer: drives the vector memory and tags each request
// with its matrix, row and end-of-row flags.
// ----------------------------------------------------------------------------
module fmv_seq #(
  parameter int MAX_COLUMNS  = 4096,
  parameter int ELEMENT_BITS = 16,
  localparam int AW          = $clog2(MAX_COLUMNS)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  fmv_pkg::cfg_t                            cfg_i,
  input  wire logic                                en_i,
  input  wire logic                                accept_i,
  input  wire logic [fmv_pkg::ModeW-1:0]           mode_i,
  input  wire logic [fmv_pkg::IndexW-1:0]          index_i,
  input  wire logic signed [fmv_pkg::ValueW-1:0]   value_i,
  output logic                                     we_o,
  output logic [AW-1:0]                            waddr_o,
  output logic signed [ELEMENT_BITS-1:0]           wdata_o,
  output logic                                     re_o,
  output logic [AW-1:0]                            raddr_o,
  output logic                                     s1_valid_o,
  output fmv_pkg::tag_t                            s1_tag_o,
  output logic signed [ELEMENT_BITS-1:0]           s1_weight_o
);
  import fmv_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int LW = (CW > RowLenW) ? CW : RowLenW;

  logic [CW-1:0]    col_q, col_d;
  logic [CrowW-1:0] crow_q, crow_d;

  logic [LW-1:0]    rl, len;
  logic [LW:0]      col_next;
  logic             row_end;
  logic [RowsW-1:0] rows_a, rows_b;
  logic [CrowW-1:0] total, sum_ab, r0, r0_inc;
  tag_t             tag;
  logic             is_load;

  logic                          s1_valid_q;
  tag_t                          s1_tag_q;
  logic signed [ELEMENT_BITS-1:0] s1_weight_q;

  assign is_load = (mode_i == MODE_LOAD);

  // store index wraps at the store depth
  generate
    if (MAX_COLUMNS >= (1 << IndexW)) begin : g_idx_wide
      assign waddr_o = AW'(index_i);
    end else begin : g_idx_mod
      localparam int    Sh     = IndexW + AW;
      localparam int    RecipW = IndexW + 2;
      localparam longint Recip = ((64'd1 << Sh) + MAX_COLUMNS - 1) / MAX_COLUMNS;
      logic [IndexW+RecipW-1:0] qprod;
      logic [IndexW-1:0]        quot, qmul, rem;
      assign qprod   = (IndexW+RecipW)'(index_i) * (IndexW+RecipW)'(Recip);
      assign quot    = IndexW'(qprod >> Sh);
      assign qmul    = IndexW'(quot * IndexW'(MAX_COLUMNS));
      assign rem     = index_i - qmul;
      assign waddr_o = AW'(rem);
    end
  endgenerate

  assign we_o    = accept_i && is_load;
  assign wdata_o = ELEMENT_BITS'(value_i);
  assign re_o    = accept_i && !is_load;
  assign raddr_o = col_q[AW-1:0];

  // effective row length
  always_comb begin
    rl = LW'(cfg_i.row_length);
    if (rl == '0) begin
      len = LW'(1);
    end else if (rl > LW'(MAX_COLUMNS)) begin
      len = LW'(MAX_COLUMNS);
    end else begin
      len = rl;
    end
    col_next = (LW+1)'(col_q) + (LW+1)'(1);
    row_end  = (col_next >= {1'b0, len});
  end

  // row bookkeeping across the matrices of a pass
  always_comb begin
    rows_a = (cfg_i.first_rows == '0) ? RowsW'(1) : cfg_i.first_rows;
    rows_b = (cfg_i.second_rows == '0) ? RowsW'(1) : cfg_i.second_rows;
    sum_ab = CrowW'(rows_a) + CrowW'(rows_b);
    case (cfg_i.layout)
      LAYOUT_PAIR:   total = {1'b0, rows_a, 1'b0};
      LAYOUT_TRIPLE: total = CrowW'(rows_a) + {1'b0, rows_b, 1'b0};
      default:       total = CrowW'(rows_a);
    endcase
    r0     = (crow_q >= total) ? '0 : crow_q;
    r0_inc = r0 + CrowW'(1);

    tag.load    = is_load;
    tag.row_end = row_end;
    tag.last    = (r0_inc >= total);
    tag.matrix  = MAT_FIRST;
    tag.row     = RowW'(r0);
    case (cfg_i.layout)
      LAYOUT_PAIR: begin
        if (r0 >= CrowW'(rows_a)) begin
          tag.matrix = MAT_SECOND;
          tag.row    = RowW'(r0 - CrowW'(rows_a));
        end
      end
      LAYOUT_TRIPLE: begin
        if (r0 >= sum_ab) begin
          tag.matrix = MAT_THIRD;
          tag.row    = RowW'(r0 - sum_ab);
        end else if (r0 >= CrowW'(rows_a)) begin
          tag.matrix = MAT_SECOND;
          tag.row    = RowW'(r0 - CrowW'(rows_a));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    col_d  = col_q;
    crow_d = crow_q;
    if (accept_i) begin
      if (is_load) begin
        col_d  = '0;
        crow_d = '0;
      end else if (row_end) begin
        col_d  = '0;
        crow_d = tag.last ? '0 : r0_inc;
      end else begin
        col_d  = CW'(col_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      crow_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      crow_q <= crow_d;
      if (en_i) begin
        s1_valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_tag_q    <= tag;
      s1_weight_q <= ELEMENT_BITS'(value_i);
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_tag_o    = s1_tag_q;
  assign s1_weight_o = s1_weight_q;

endmodule
`default_nettype wire

[hdl/fmv_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmv_mac
// Multiply stage, 48-bit accumulator and result output register.
// ----------------------------------------------------------------------------
module fmv_mac #(
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               s1_valid_i,
  input  fmv_pkg::tag_t                           s1_tag_i,
  input  wire logic signed [ELEMENT_BITS-1:0]     s1_weight_i,
  input  wire logic signed [ELEMENT_BITS-1:0]     rd_data_i,
  output logic                                    valid_o,
  output logic [fmv_pkg::MatrixW-1:0]             matrix_o,
  output logic [fmv_pkg::RowW-1:0]                row_o,
  output logic signed [fmv_pkg::ResultW-1:0]      result_o,
  output logic                                    last_o
);
  import fmv_pkg::*;

  localparam int PW = 2 * ELEMENT_BITS;

  logic                    s2_valid_q;
  tag_t                    s2_tag_q;
  logic signed [PW-1:0]    prod_d, prod_q;
  logic signed [ResultW-1:0] prod_ext, sum, acc_q, acc_d;
  logic                    out_valid_q, out_valid_d;
  logic                    emit;
  logic [MatrixW-1:0]      matrix_q;
  logic [RowW-1:0]         row_q;
  logic signed [ResultW-1:0] result_q;
  logic                    last_q;

  assign prod_d   = s1_weight_i * rd_data_i;
  // wraps modulo 2^48 when the product is wider
  assign prod_ext = ResultW'(prod_q);
  assign sum      = acc_q + prod_ext;
  assign emit     = s2_valid_q && !s2_tag_q.load && s2_tag_q.row_end;

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (en_i) begin
      out_valid_d = emit;
      if (s2_valid_q) begin
        if (s2_tag_q.load || s2_tag_q.row_end) begin
          acc_d = '0;
        end else begin
          acc_d = sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (en_i) begin
        s2_valid_q <= s1_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_tag_q <= s1_tag_i;
      prod_q   <= prod_d;
      if (emit) begin
        matrix_q <= s2_tag_q.matrix;
        row_q    <= s2_tag_q.row;
        result_q <= sum;
        last_q   <= s2_tag_q.last;
      end
    end
  end

  assign valid_o  = out_valid_q;
  assign matrix_o = matrix_q;
  assign row_o    = row_q;
  assign result_o = result_q;
  assign last_o   = last_q;

endmodule
`default_nettype wire

[hdl/fused_matrix_vector_multiply.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fused_matrix_vector_multiply
// Streams one, two or three weight matrices against a shared stored vector.
// ----------------------------------------------------------------------------
// Usage:
//   Program row_length, layout, first_rows and second_rows over APB while the
//   block is idle. Requests on req_i with mode 0 load a vector element into
//   the vector memory at vector_index; mode 1 requests stream weights row by
//   row. After the last column of a row a result leaves on res_o with the
//   matrix code, the row within that matrix, the exact 48-bit dot product
//   and a last flag on the final row of the pass.
//   Throughput is one request per cycle while no result stalls. The result
//   of the request that closes a row is registered after the vector memory
//   read, the multiply and the accumulate into the output register.
//   While a result waits on res_o with ready low, the whole pipeline holds
//   and req_i.ready is low; otherwise requests flow on every cycle.
//   Reset clears the counters, the accumulator and the pipeline valids and
//   restores the register defaults; the vector memory keeps no reset value
//   and every element must be loaded before it is used.
// ----------------------------------------------------------------------------
module fused_matrix_vector_multiply #(
  parameter int MAX_COLUMNS  = 4096,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [fmv_pkg::CfgAddrW-1:0]  paddr_i,
  input  wire logic [fmv_pkg::CfgDataW-1:0]  pwdata_i,
  output logic      [fmv_pkg::CfgDataW-1:0]  prdata_o,
  output logic                               pready_o,
  fmv_req_if.sink                            req_i,
  fmv_res_if.source                          res_o
);
  import fmv_pkg::*;

  localparam int AW = $clog2(MAX_COLUMNS);

  cfg_t                           cfg;
  logic                           en, accept;
  logic                           we, re;
  logic [AW-1:0]                  waddr, raddr;
  logic signed [ELEMENT_BITS-1:0] wdata, rd_data, s1_weight;
  logic                           s1_valid;
  tag_t                           s1_tag;
  logic                           res_valid;

  assign en          = !res_valid || res_o.ready;
  assign req_i.ready = en;
  assign accept      = req_i.valid && en;

  fmv_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  fmv_seq #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .en_i        (en),
    .accept_i    (accept),
    .mode_i      (req_i.mode),
    .index_i     (req_i.vector_index),
    .value_i     (req_i.value),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .s1_valid_o  (s1_valid),
    .s1_tag_o    (s1_tag),
    .s1_weight_o (s1_weight)
  );

  fmv_vstore #(
    .DEPTH (MAX_COLUMNS),
    .WIDTH (ELEMENT_BITS)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  fmv_mac #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .s1_valid_i  (s1_valid),
    .s1_tag_i    (s1_tag),
    .s1_weight_i (s1_weight),
    .rd_data_i   (rd_data),
    .valid_o     (res_valid),
    .matrix_o    (res_o.matrix),
    .row_o       (res_o.row),
    .result_o    (res_o.result),
    .last_o      (res_o.last)
  );

  assign res_o.valid = res_valid;

`ifndef SYNTHESIS
  // a waiting result must hold back new requests
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_o.ready) |-> !req_i.ready)
    else $error("request accepted while a result is stalled");

  a_matrix_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_o.matrix == MAT_FIRST || res_o.matrix == MAT_SECOND ||
                   res_o.matrix == MAT_THIRD))
    else $error("result carries an unused matrix code");

  // single layout only ever reports the first matrix
  a_single_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && cfg.layout != LAYOUT_PAIR && cfg.layout != LAYOUT_TRIPLE)
      |-> res_o.matrix == MAT_FIRST)
    else $error("single layout result tagged with a later matrix");
`endif

endmodule
`default_nettype wire
